// ===== rtl/two_colour_tile_palette_decoder_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the tile decoder checker
// ---------------------------------------------------------------------------
`ifndef TWO_COLOUR_TILE_PALETTE_DECODER_UNIT_DEFINES_SVH
`define TWO_COLOUR_TILE_PALETTE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define TCPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only out of reset.
`define TCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcpd_pkg.sv =====
// ---------------------------------------------------------------------------
// tcpd_pkg
// Shared constants and helpers of the two-colour tile palette decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tcpd_pkg;

    localparam int DEF_PALETTE_ENTRIES  = 256;
    localparam int DEF_MAX_TILES_ACROSS = 1024;
    localparam int TILE_ROWS_LIMIT      = 1024;
    localparam int TILE_SIDE            = 4;
    localparam int TILE_PIXELS          = 16;

    localparam int COUNT_W = 11;   // tiles_across / tiles_down
    localparam int TILE_W  = 10;   // tile column / row counter
    localparam int COORD_W = 12;   // pixel_x / pixel_y
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int MAP_W   = 16;
    localparam int K_W     = 4;

    localparam logic [COUNT_W-1:0] RST_TILES_ACROSS = 11'd160;
    localparam logic [COUNT_W-1:0] RST_TILES_DOWN   = 11'd120;

    // configuration register indexes
    localparam logic CFG_TILES_ACROSS = 1'b0;
    localparam logic CFG_TILES_DOWN   = 1'b1;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TILE = 1'b1;

    // Zero acts as one, anything above hi acts as hi.
    function automatic logic [COUNT_W-1:0] clamp_count(
        input logic [COUNT_W-1:0] v,
        input logic [COUNT_W-1:0] hi
    );
        logic [COUNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = COUNT_W'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/two_colour_tile_palette_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// two_colour_tile_palette_decoder_unit
// Decodes 4x4 two-color tiles into RGB pixels through a palette memory.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                    Payload
//  -------  ---------  ---------------------------  ----------------------------
//  in       sink       i_in_valid / o_in_ready      opcode, palette index, load
//                                                   bytes, color indices, map
//  out      source     o_out_valid / i_out_ready    red, green, blue, x, y, last
//  cfg      sink       i_cfg_we (no wait)           register index, data
//
//  A tile request yields 16 pixels, one per cycle while the output is not
//  stalled; the single read port of the palette memory sets that rate. A new
//  tile can be taken as the previous one issues its last pixel; each pixel
//  passes the palette read register and the output register. A palette load
//  waits until every palette read of earlier tiles has completed (nothing
//  left in the read stage). Output stalls freeze the whole pixel pipe.
//  Reset (synchronous, active low) clears the tile counter and the pipe and
//  presets the configuration registers; palette contents are undefined until loaded.
//
`default_nettype none

module two_colour_tile_palette_decoder_unit #(
    parameter int PALETTE_ENTRIES  = tcpd_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_TILES_ACROSS = tcpd_pkg::DEF_MAX_TILES_ACROSS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request channel
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_opcode,
    input  wire  [tcpd_pkg::INDEX_W-1:0]      i_palette_index,
    input  wire  [tcpd_pkg::COLOR_W-1:0]      i_load_red,
    input  wire  [tcpd_pkg::COLOR_W-1:0]      i_load_green,
    input  wire  [tcpd_pkg::COLOR_W-1:0]      i_load_blue,
    input  wire  [tcpd_pkg::INDEX_W-1:0]      i_colour_one,
    input  wire  [tcpd_pkg::INDEX_W-1:0]      i_colour_zero,
    input  wire  [tcpd_pkg::MAP_W-1:0]        i_colour_map,
    // pixel channel
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [tcpd_pkg::COLOR_W-1:0]      o_red,
    output logic [tcpd_pkg::COLOR_W-1:0]      o_green,
    output logic [tcpd_pkg::COLOR_W-1:0]      o_blue,
    output logic [tcpd_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [tcpd_pkg::COORD_W-1:0]      o_pixel_y,
    output logic                              o_last,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_index,
    input  wire  [tcpd_pkg::COUNT_W-1:0]      i_cfg_data
);
    import tcpd_pkg::*;

    localparam int AW      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int RGB_W   = 3 * COLOR_W;
    localparam logic [INDEX_W:0]   ENTRIES_LIM = (INDEX_W+1)'(PALETTE_ENTRIES);
    localparam logic [COUNT_W-1:0] ACROSS_MAX  = COUNT_W'(MAX_TILES_ACROSS);
    localparam logic [COUNT_W-1:0] DOWN_MAX    = COUNT_W'(TILE_ROWS_LIMIT);
    localparam logic [K_W-1:0]     K_LAST      = K_W'(TILE_PIXELS - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] r_tiles_across;
    logic [COUNT_W-1:0] r_tiles_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_across <= RST_TILES_ACROSS;
            r_tiles_down   <= RST_TILES_DOWN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TILES_ACROSS: r_tiles_across <= i_cfg_data;
                CFG_TILES_DOWN:   r_tiles_down   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipe control: everything past the sequencer moves together when
    // the output register is empty or being drained.
    // ---------------------------------------------------------------
    logic advance;
    assign advance = !o_out_valid || i_out_ready;

    // sequencer state (the tile being issued)
    logic               r_busy;
    logic [K_W-1:0]     r_k;
    logic [INDEX_W-1:0] r_c1;
    logic [INDEX_W-1:0] r_c0;
    logic [MAP_W-1:0]   r_map;
    logic [TILE_W-1:0]  r_tcol;
    logic [TILE_W-1:0]  r_trow;

    // read stage (palette data arrives in the cycle after issue)
    logic               r_s1_valid;
    logic               r_s1_black;
    logic               r_s1_last;
    logic [COORD_W-1:0] r_s1_px;
    logic [COORD_W-1:0] r_s1_py;

    // running tile position of the next tile
    logic [TILE_W-1:0]  r_col;
    logic [TILE_W-1:0]  r_row;

    // ---------------------------------------------------------------
    // Request acceptance. A tile may enter as the previous one issues
    // its last pixel. A load waits until no palette read is in flight,
    // so earlier tiles never see the new entry.
    // ---------------------------------------------------------------
    logic tile_ready;
    logic load_ready;
    logic tile_acc;
    logic load_acc;

    assign tile_ready = !r_busy || (advance && (r_k == K_LAST));
    assign load_ready = !r_busy && !r_s1_valid;
    assign o_in_ready = (i_opcode == OP_TILE) ? tile_ready : load_ready;
    assign tile_acc   = i_in_valid && o_in_ready && (i_opcode == OP_TILE);
    assign load_acc   = i_in_valid && o_in_ready && (i_opcode == OP_LOAD);

    // ---------------------------------------------------------------
    // Tile counter: move across, then down, wrap after the last tile.
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] across_eff;
    logic [COUNT_W-1:0] down_eff;
    logic [TILE_W-1:0]  n_col;
    logic [TILE_W-1:0]  n_row;

    always_comb begin
        across_eff = clamp_count(r_tiles_across, ACROSS_MAX);
        down_eff   = clamp_count(r_tiles_down, DOWN_MAX);
        n_col      = r_col + TILE_W'(1);
        n_row      = r_row;
        if (({1'b0, r_col} + COUNT_W'(1)) >= across_eff) begin
            n_col = '0;
            if (({1'b0, r_row} + COUNT_W'(1)) >= down_eff) begin
                n_row = '0;
            end else begin
                n_row = r_row + TILE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (tile_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: one palette read per cycle while the pipe advances, pixel k of the tile.
    // ---------------------------------------------------------------
    logic               issue;
    logic               map_bit;
    logic [INDEX_W-1:0] rd_idx;
    logic               rd_in_range;

    assign issue       = r_busy && advance;
    assign map_bit     = r_map[K_LAST - r_k];
    assign rd_idx      = map_bit ? r_c1 : r_c0;
    assign rd_in_range = {1'b0, rd_idx} < ENTRIES_LIM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (tile_acc) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (issue) begin
            r_k <= r_k + K_W'(1);
            if (r_k == K_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // hold the tile's payload while it is issued
    always_ff @(posedge i_clk) begin
        if (tile_acc) begin
            r_c1   <= i_colour_one;
            r_c0   <= i_colour_zero;
            r_map  <= i_colour_map;
            r_tcol <= r_col;
            r_trow <= r_row;
        end
    end

    // ---------------------------------------------------------------
    // Palette memory: one write port for loads, one registered read.
    // Loads and reads never share a cycle (see load_ready).
    // ---------------------------------------------------------------
    logic [RGB_W-1:0] r_palette [PALETTE_ENTRIES];
    logic [RGB_W-1:0] r_rd_data;
    logic             wr_en;

    assign wr_en = load_acc && ({1'b0, i_palette_index} < ENTRIES_LIM);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_palette[i_palette_index[AW-1:0]] <= {i_load_red, i_load_green, i_load_blue};
        end
        if (issue) begin
            r_rd_data <= r_palette[rd_idx[AW-1:0]];
        end
    end

    // read stage bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_black <= !rd_in_range;
            r_s1_last  <= (r_k == K_LAST);
            r_s1_px    <= {r_tcol, r_k[1:0]};
            r_s1_py    <= {r_trow, r_k[3:2]};
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance) begin
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            // out-of-range index reads as black
            o_red     <= r_s1_black ? '0 : r_rd_data[RGB_W-1 -: COLOR_W];
            o_green   <= r_s1_black ? '0 : r_rd_data[2*COLOR_W-1 -: COLOR_W];
            o_blue    <= r_s1_black ? '0 : r_rd_data[COLOR_W-1:0];
            o_pixel_x <= r_s1_px;
            o_pixel_y <= r_s1_py;
            o_last    <= r_s1_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcpd_checker.sv =====
// ---------------------------------------------------------------------------
// tcpd_checker
// Port-level checks of the tile decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "two_colour_tile_palette_decoder_unit_defines.svh"

module tcpd_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire [tcpd_pkg::COLOR_W-1:0]  o_red,
    input wire [tcpd_pkg::COORD_W-1:0]  o_pixel_x,
    input wire [tcpd_pkg::COORD_W-1:0]  o_pixel_y,
    input wire                          o_last
);
    import tcpd_pkg::*;

    // a stalled pixel keeps its position and its red channel
    `TCPD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_red) && o_out_valid, "stalled pixel changed")

    // last marks the bottom-right pixel of the tile and only that one
    `TCPD_ASSERT_NOW(a_last_pos, o_out_valid, o_last == ((o_pixel_x[1:0] == 2'd3) && (o_pixel_y[1:0] == 2'd3)), "last flag out of place")

    // a pixel that does not end its tile row is followed by one on the same row
    `TCPD_ASSERT_NEXT(a_raster, o_out_valid && i_out_ready && !o_last && (o_pixel_x[1:0] != 2'd3), !o_out_valid || (o_pixel_y == $past(o_pixel_y)), "pixel left its tile row")

    // nothing is shown right out of reset
    `TCPD_ASSERT_NOW(a_rst_empty, $rose(i_rst_n), !o_out_valid, "pixel valid right after reset")

endmodule

bind two_colour_tile_palette_decoder_unit tcpd_checker u_tcpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_red       (o_red),
    .o_pixel_x   (o_pixel_x),
    .o_pixel_y   (o_pixel_y),
    .o_last      (o_last)
);

`default_nettype wire
